### hdl/fsrq_pkg.sv
// Shared types and constants of the fair-share run queue.
package fsrq_pkg;

  // Operation codes carried in the op field
  localparam logic [2:0] OP_ENQUEUE = 3'd0;
  localparam logic [2:0] OP_DEQUEUE = 3'd1;
  localparam logic [2:0] OP_TICK    = 3'd2;
  localparam logic [2:0] OP_SLICE   = 3'd3;
  localparam logic [2:0] OP_WAKEUP  = 3'd4;
  localparam logic [2:0] OP_PICK    = 3'd5;
  localparam logic [2:0] OP_SETCUR  = 3'd6;

  // Configuration register indexes
  localparam logic [2:0] REG_NICE0_WEIGHT    = 3'd0;
  localparam logic [2:0] REG_TARGET_LATENCY  = 3'd1;
  localparam logic [2:0] REG_MIN_GRANULARITY = 3'd2;
  localparam logic [2:0] REG_LATENCY_LIMIT   = 3'd3;
  localparam logic [2:0] REG_TIME_UNIT       = 3'd4;
  localparam logic [2:0] REG_WAKEUP_GRAN     = 3'd5;

  // Saturation value and the floor level that triggers the vruntime clear
  localparam logic [31:0] VR_MAX       = 32'hFFFF_FFFF;
  localparam logic [31:0] FLOOR_LIMIT  = 32'hFFFF_FFF5;

  // One slot record as kept in the slot memory
  typedef struct packed {
    logic [31:0] vr;
    logic [19:0] weight;
    logic [31:0] run_total;
    logic [31:0] run_snap;
    logic [31:0] stamp;
  } rec_t;

  // Wrap-aware "a is before b"
  function automatic logic wrap_less(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

endpackage

### hdl/fair_share_run_queue_top.sv
// Fair-share run queue: slot memory, sequencer, scan and shared divider.
//
//  channel | direction | handshake                | payload
//  s_axis  | in        | s_axis_tvalid/tready     | op, task_slot, weight, vruntime, elapsed
//  m_axis  | out       | m_axis_tvalid/tready     | chosen_slot, found, preempt, floor, count
//  cfg     | in        | cfg_we_i (write only)    | cfg_addr_i index, cfg_wdata_i value
//
// One item at a time. Pick scans the slot memory, one slot per cycle.
// Tick adds a divider pass when the weight is not nice0, then the scan,
// and a sweep of the memory when the floor clear runs. Slice checks take
// two divider passes, wakeup checks up to two. Reset is asynchronous: it
// clears the queue state and loads the configuration defaults, but not the
// slot memory. A result waiting on m_axis holds the sequencer in its last step.
module fair_share_run_queue_top #(
  parameter int NUM_SLOTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [2:0] op, [7:3] task_slot, [27:8] task_weight, [59:28] initial_vruntime,
  // [91:60] elapsed, [95:92] zero
  input  logic [95:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [4:0] chosen_slot, [5] found, [6] preempt, [38:7] floor_vruntime,
  // [44:39] queued_count, [47:45] zero
  output logic [47:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);

  // Sequencer states
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_RD     = 5'd1;
  localparam logic [4:0] ST_EX     = 5'd2;
  localparam logic [4:0] ST_TMUL   = 5'd3;
  localparam logic [4:0] ST_TDIV   = 5'd4;
  localparam logic [4:0] ST_TWR    = 5'd5;
  localparam logic [4:0] ST_SCAN   = 5'd6;
  localparam logic [4:0] ST_SCANL  = 5'd7;
  localparam logic [4:0] ST_TMIN   = 5'd8;
  localparam logic [4:0] ST_CLR    = 5'd9;
  localparam logic [4:0] ST_CLRL   = 5'd10;
  localparam logic [4:0] ST_SMUL1  = 5'd11;
  localparam logic [4:0] ST_SDIV1  = 5'd12;
  localparam logic [4:0] ST_SMUL2  = 5'd13;
  localparam logic [4:0] ST_SDIV2  = 5'd14;
  localparam logic [4:0] ST_SCMP   = 5'd15;
  localparam logic [4:0] ST_WRD    = 5'd16;
  localparam logic [4:0] ST_WEX    = 5'd17;
  localparam logic [4:0] ST_WDIV1  = 5'd18;
  localparam logic [4:0] ST_WSC    = 5'd19;
  localparam logic [4:0] ST_WDIV2  = 5'd20;
  localparam logic [4:0] ST_WCMP   = 5'd21;
  localparam logic [4:0] ST_DWAIT  = 5'd22;
  localparam logic [4:0] ST_DONE   = 5'd23;

  // Configuration
  logic [19:0] nice0_q;
  logic [31:0] target_q;
  logic [31:0] min_gran_q;
  logic [6:0]  lat_limit_q;
  logic [31:0] time_unit_q;
  logic [31:0] wake_gran_q;

  // Queue state
  logic [NUM_SLOTS-1:0] queued_q;
  logic [NUM_SLOTS-1:0] touched_q;
  logic [31:0]          stamp_q;
  logic [31:0]          load_q;
  logic [CW-1:0]        cnt_q;
  logic [31:0]          floor_q;
  logic [SW-1:0]        cur_q;
  logic                 cur_v_q;

  // Sequencer and working registers
  logic [4:0]    state_q;
  logic [4:0]    dnext_q;
  logic [2:0]    op_q;
  logic [SW-1:0] slot_q;
  logic [19:0]   w_q;
  logic [31:0]   vin_q;
  logic [31:0]   el_q;
  logic [SW-1:0] rd_addr_q;
  fsrq_pkg::rec_t rec_q;
  logic [31:0]   acc_q;
  logic [31:0]   diff_q;
  logic [19:0]   ws_q;
  logic [CW:0]   nr_q;
  logic          preempt_q;

  // Scan registers
  logic [SW-1:0] scan_q;
  logic [SW-1:0] pend_q;
  logic          pend_v_q;
  logic          best_v_q;
  logic [SW-1:0] best_idx_q;
  logic [31:0]   best_vr_q;
  logic [31:0]   best_st_q;

  // Output register
  logic        m_valid_q;
  logic [47:0] m_data_q;

  // Memory and divider ports
  fsrq_pkg::rec_t rdata;
  fsrq_pkg::rec_t wdata;
  logic           we;
  logic [SW-1:0]  waddr;
  logic [SW-1:0]  raddr;
  logic           div_start;
  logic [31:0]    div_a;
  logic [31:0]    div_b;
  logic           div_done;
  logic [31:0]    div_q;

  // Input fields
  logic [2:0]    in_op;
  logic [4:0]    in_slot;
  logic          in_ok;
  logic [SW-1:0] in_idx;

  // Derived values
  logic [31:0] rt_eff;
  logic [31:0] snap_eff;
  logic        cur_on;
  logic [CW:0] nr;
  logic [31:0] load;
  logic [32:0] vr_sum;
  logic [31:0] vr_new;
  logic        upd;
  logic [31:0] cand;
  logic [31:0] new_floor;
  logic [31:0] wdiff;

  assign in_op   = s_axis_tdata_i[2:0];
  assign in_slot = s_axis_tdata_i[7:3];
  assign in_ok   = 32'(in_slot) < NUM_SLOTS;
  assign in_idx  = SW'(in_slot);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  fsrq_ram #(
    .WIDTH($bits(fsrq_pkg::rec_t)),
    .DEPTH(NUM_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  fsrq_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_a),
    .divisor_i (div_b),
    .done_o    (div_done),
    .quot_o    (div_q)
  );

  // Totals of a slot never written read as zero
  assign rt_eff   = touched_q[rd_addr_q] ? rdata.run_total : '0;
  assign snap_eff = touched_q[rd_addr_q] ? rdata.run_snap : '0;
  assign cur_on   = queued_q[cur_q];
  assign nr       = (CW + 1)'(cnt_q) + (CW + 1)'(!cur_on);
  assign load     = load_q + (cur_on ? 32'd0 : 32'(rec_q.weight));

  // Saturating vruntime update for tick
  assign vr_sum = {1'b0, rec_q.vr} + {1'b0, acc_q};
  assign vr_new = (vr_sum >= {1'b0, fsrq_pkg::VR_MAX}) ? fsrq_pkg::VR_MAX : vr_sum[31:0];

  // Scan compare: strictly before in vruntime, ties to the older stamp
  assign upd = queued_q[pend_q] &&
               (!best_v_q || fsrq_pkg::wrap_less(rdata.vr, best_vr_q) ||
                (rdata.vr == best_vr_q && fsrq_pkg::wrap_less(rdata.stamp, best_st_q)));

  // Floor candidate after a tick
  always_comb begin
    cand = cur_on ? rec_q.vr : floor_q;
    if (best_v_q) begin
      if (!cur_on || fsrq_pkg::wrap_less(best_vr_q, cand)) begin
        cand = best_vr_q;
      end
    end
    new_floor = fsrq_pkg::wrap_less(floor_q, cand) ? cand : floor_q;
  end

  assign wdiff = rec_q.vr - rdata.vr;

  // Memory read address: scan counter while sweeping, else the held address
  assign raddr = (state_q == ST_SCAN || state_q == ST_CLR) ? scan_q : rd_addr_q;

  // Memory write port
  always_comb begin
    we    = 1'b0;
    waddr = rd_addr_q;
    wdata = rec_q;
    case (state_q)
      ST_EX: begin
        if (op_q == fsrq_pkg::OP_ENQUEUE) begin
          we    = 1'b1;
          wdata = '{vr: vin_q, weight: w_q, run_total: rt_eff, run_snap: snap_eff,
                    stamp: stamp_q};
        end else if (op_q == fsrq_pkg::OP_SETCUR) begin
          we              = 1'b1;
          wdata           = rdata;
          wdata.run_total = rt_eff;
          wdata.run_snap  = rt_eff;
        end
      end
      ST_TWR: begin
        we       = 1'b1;
        waddr    = cur_q;
        wdata.vr = vr_new;
        if (cur_on) begin
          wdata.stamp = stamp_q;
        end
      end
      ST_CLR, ST_CLRL: begin
        we       = pend_v_q && queued_q[pend_q];
        waddr    = pend_q;
        wdata    = rdata;
        wdata.vr = '0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Divider operands
  always_comb begin
    div_start = 1'b0;
    div_a     = acc_q;
    div_b     = time_unit_q;
    case (state_q)
      ST_TDIV: begin
        div_start = 1'b1;
        div_b     = 32'(rec_q.weight);
      end
      ST_SDIV1: begin
        div_start = 1'b1;
      end
      ST_SDIV2: begin
        div_start = 1'b1;
        div_b     = load;
      end
      ST_WDIV1: begin
        div_start = 1'b1;
        div_a     = wake_gran_q;
      end
      ST_WDIV2: begin
        div_start = 1'b1;
        div_b     = 32'(ws_q);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nice0_q     <= 20'd1024;
      target_q    <= 32'd6000000;
      min_gran_q  <= 32'd750000;
      lat_limit_q <= 7'd8;
      time_unit_q <= 32'd1;
      wake_gran_q <= 32'd1000000;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        fsrq_pkg::REG_NICE0_WEIGHT:    nice0_q     <= cfg_wdata_i[19:0];
        fsrq_pkg::REG_TARGET_LATENCY:  target_q    <= cfg_wdata_i;
        fsrq_pkg::REG_MIN_GRANULARITY: min_gran_q  <= cfg_wdata_i;
        fsrq_pkg::REG_LATENCY_LIMIT:   lat_limit_q <= cfg_wdata_i[6:0];
        fsrq_pkg::REG_TIME_UNIT:       time_unit_q <= cfg_wdata_i;
        fsrq_pkg::REG_WAKEUP_GRAN:     wake_gran_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      dnext_q    <= ST_IDLE;
      queued_q   <= '0;
      touched_q  <= '0;
      stamp_q    <= '0;
      load_q     <= '0;
      cnt_q      <= '0;
      floor_q    <= '0;
      cur_q      <= '0;
      cur_v_q    <= 1'b0;
      op_q       <= '0;
      slot_q     <= '0;
      w_q        <= '0;
      vin_q      <= '0;
      el_q       <= '0;
      rd_addr_q  <= '0;
      rec_q      <= '0;
      acc_q      <= '0;
      diff_q     <= '0;
      ws_q       <= '0;
      nr_q       <= '0;
      preempt_q  <= 1'b0;
      scan_q     <= '0;
      pend_q     <= '0;
      pend_v_q   <= 1'b0;
      best_v_q   <= 1'b0;
      best_idx_q <= '0;
      best_vr_q  <= '0;
      best_st_q  <= '0;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
    end else begin
      // Drop the result once taken, unless a new one is loaded now
      if (m_valid_q && m_axis_tready_i && state_q != ST_DONE) begin
        m_valid_q <= 1'b0;
      end

      // Merge the pending scan entry
      if ((state_q == ST_SCAN && pend_v_q) || state_q == ST_SCANL) begin
        if (upd) begin
          best_v_q   <= 1'b1;
          best_idx_q <= pend_q;
          best_vr_q  <= rdata.vr;
          best_st_q  <= rdata.stamp;
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            op_q      <= in_op;
            slot_q    <= in_idx;
            w_q       <= s_axis_tdata_i[27:8];
            vin_q     <= s_axis_tdata_i[59:28];
            el_q      <= s_axis_tdata_i[91:60];
            preempt_q <= 1'b0;
            scan_q    <= '0;
            pend_v_q  <= 1'b0;
            best_v_q  <= 1'b0;
            case (in_op)
              fsrq_pkg::OP_ENQUEUE: begin
                rd_addr_q <= in_idx;
                state_q   <= (in_ok && !queued_q[in_idx]) ? ST_RD : ST_DONE;
              end
              fsrq_pkg::OP_DEQUEUE: begin
                rd_addr_q <= in_idx;
                state_q   <= (in_ok && queued_q[in_idx]) ? ST_RD : ST_DONE;
              end
              fsrq_pkg::OP_TICK, fsrq_pkg::OP_SLICE: begin
                rd_addr_q <= cur_q;
                state_q   <= cur_v_q ? ST_RD : ST_DONE;
              end
              fsrq_pkg::OP_WAKEUP: begin
                rd_addr_q <= cur_q;
                state_q   <= (cur_v_q && in_ok && in_idx != cur_q) ? ST_RD : ST_DONE;
              end
              fsrq_pkg::OP_PICK: begin
                state_q <= ST_SCAN;
              end
              fsrq_pkg::OP_SETCUR: begin
                rd_addr_q <= in_idx;
                state_q   <= in_ok ? ST_RD : ST_DONE;
              end
              default: begin
                state_q <= ST_DONE;
              end
            endcase
          end
        end

        ST_RD: begin
          state_q <= ST_EX;
        end

        ST_EX: begin
          case (op_q)
            fsrq_pkg::OP_ENQUEUE: begin
              queued_q[slot_q]  <= 1'b1;
              touched_q[slot_q] <= 1'b1;
              load_q            <= load_q + 32'(w_q);
              cnt_q             <= cnt_q + CW'(1);
              stamp_q           <= stamp_q + 32'd1;
              state_q           <= ST_DONE;
            end
            fsrq_pkg::OP_DEQUEUE: begin
              queued_q[slot_q] <= 1'b0;
              load_q           <= load_q - 32'(rdata.weight);
              cnt_q            <= cnt_q - CW'(1);
              state_q          <= ST_DONE;
            end
            fsrq_pkg::OP_TICK: begin
              rec_q <= '{vr: rdata.vr, weight: rdata.weight, run_total: rt_eff + el_q,
                         run_snap: snap_eff, stamp: rdata.stamp};
              if (rdata.weight == nice0_q) begin
                acc_q   <= el_q;
                state_q <= ST_TWR;
              end else begin
                state_q <= ST_TMUL;
              end
            end
            fsrq_pkg::OP_SLICE: begin
              rec_q <= '{vr: rdata.vr, weight: rdata.weight, run_total: rt_eff,
                         run_snap: snap_eff, stamp: rdata.stamp};
              nr_q  <= nr;
              if (32'(nr) > 32'(lat_limit_q)) begin
                state_q <= ST_SMUL1;
              end else begin
                acc_q   <= target_q;
                state_q <= ST_SDIV1;
              end
            end
            fsrq_pkg::OP_WAKEUP: begin
              rec_q     <= rdata;
              rd_addr_q <= slot_q;
              state_q   <= ST_WRD;
            end
            fsrq_pkg::OP_SETCUR: begin
              cur_q             <= slot_q;
              cur_v_q           <= 1'b1;
              touched_q[slot_q] <= 1'b1;
              state_q           <= ST_DONE;
            end
            default: begin
              state_q <= ST_DONE;
            end
          endcase
        end

        // Tick: scale elapsed time by nice0 / weight
        ST_TMUL: begin
          acc_q   <= 32'(el_q * 32'(nice0_q));
          state_q <= ST_TDIV;
        end
        ST_TDIV: begin
          dnext_q <= ST_TWR;
          state_q <= ST_DWAIT;
        end
        ST_TWR: begin
          rec_q.vr         <= vr_new;
          touched_q[cur_q] <= 1'b1;
          if (cur_on) begin
            stamp_q <= stamp_q + 32'd1;
          end
          scan_q   <= '0;
          pend_v_q <= 1'b0;
          best_v_q <= 1'b0;
          state_q  <= ST_SCAN;
        end

        // Leftmost scan, one slot per cycle
        ST_SCAN: begin
          pend_q   <= scan_q;
          pend_v_q <= 1'b1;
          if (scan_q == SW'(NUM_SLOTS - 1)) begin
            state_q <= ST_SCANL;
          end else begin
            scan_q <= scan_q + SW'(1);
          end
        end
        ST_SCANL: begin
          state_q <= (op_q == fsrq_pkg::OP_PICK) ? ST_DONE : ST_TMIN;
        end

        // Advance the floor and clear all queued vruntimes near overflow
        ST_TMIN: begin
          if (new_floor >= fsrq_pkg::FLOOR_LIMIT) begin
            floor_q  <= '0;
            scan_q   <= '0;
            pend_v_q <= 1'b0;
            state_q  <= ST_CLR;
          end else begin
            floor_q <= new_floor;
            state_q <= ST_DONE;
          end
        end
        ST_CLR: begin
          pend_q   <= scan_q;
          pend_v_q <= 1'b1;
          if (scan_q == SW'(NUM_SLOTS - 1)) begin
            state_q <= ST_CLRL;
          end else begin
            scan_q <= scan_q + SW'(1);
          end
        end
        ST_CLRL: begin
          state_q <= ST_DONE;
        end

        // Slice check
        ST_SMUL1: begin
          acc_q   <= 32'(32'(nr_q) * min_gran_q);
          state_q <= ST_SDIV1;
        end
        ST_SDIV1: begin
          dnext_q <= ST_SMUL2;
          state_q <= ST_DWAIT;
        end
        ST_SMUL2: begin
          acc_q   <= 32'(acc_q * 32'(rec_q.weight));
          state_q <= ST_SDIV2;
        end
        ST_SDIV2: begin
          dnext_q <= ST_SCMP;
          state_q <= ST_DWAIT;
        end
        ST_SCMP: begin
          preempt_q <= (rec_q.run_total - rec_q.run_snap) > acc_q;
          state_q   <= ST_DONE;
        end

        // Wakeup check
        ST_WRD: begin
          state_q <= ST_WEX;
        end
        ST_WEX: begin
          ws_q   <= rdata.weight;
          diff_q <= wdiff;
          if (wdiff == 32'd0 || wdiff[31]) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_WDIV1;
          end
        end
        ST_WDIV1: begin
          dnext_q <= ST_WSC;
          state_q <= ST_DWAIT;
        end
        ST_WSC: begin
          if (ws_q == nice0_q) begin
            state_q <= ST_WCMP;
          end else begin
            acc_q   <= 32'(acc_q * 32'(nice0_q));
            state_q <= ST_WDIV2;
          end
        end
        ST_WDIV2: begin
          dnext_q <= ST_WCMP;
          state_q <= ST_DWAIT;
        end
        ST_WCMP: begin
          preempt_q <= diff_q > acc_q;
          state_q   <= ST_DONE;
        end

        // Hold until the divider returns
        ST_DWAIT: begin
          if (div_done) begin
            acc_q   <= div_q;
            state_q <= dnext_q;
          end
        end

        // Load the result once the output register is free
        ST_DONE: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {3'b000, 6'(cnt_q), floor_q, preempt_q,
                          (op_q == fsrq_pkg::OP_PICK) && best_v_q,
                          ((op_q == fsrq_pkg::OP_PICK) && best_v_q) ? 5'(best_idx_q) : 5'd0};
            state_q   <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/fsrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fsrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and register the read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/fsrq_div.sv
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
module fsrq_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [31:0] quot_q;
  logic [31:0] rem_q;
  logic [31:0] dvs_q;
  logic [32:0] trial;
  logic [32:0] diff;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, quot_q[31]};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quot_q <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      // Flag the last quotient bit
      done_q <= busy_q && !start_i && (cnt_q == 6'd1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
        quot_q <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        // A zero divisor always subtracts, giving all ones
        if (!diff[32]) begin
          rem_q  <= diff[31:0];
          quot_q <= {quot_q[30:0], 1'b1};
        end else begin
          rem_q  <= trial[31:0];
          quot_q <= {quot_q[30:0], 1'b0};
        end
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
